// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the trie set.
// Depends on nothing; the checks compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// An expression that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/btmx_pkg.sv
// Types and constants of the binary trie minimum-xor set.
// Used by binary_trie_min_xor_set; depends on nothing.
`default_nettype none
package btmx_pkg;

  localparam int KEY_BITS  = 31;
  localparam int VAL_W     = 31;
  localparam int NODE_POOL = 4096;
  localparam int PTR_W     = $clog2(NODE_POOL);
  localparam int NODE_W    = 2 * PTR_W;
  localparam int CNT_W     = $clog2(NODE_POOL + 1);
  localparam int LVL_W     = $clog2(KEY_BITS + 1);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_XOR    = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_IWALK,
    ST_ALLOC,
    ST_QWALK
  } state_t;

  // Child link of a node word for the given key bit.
  function automatic logic [PTR_W-1:0] child_of(input logic [NODE_W-1:0] node,
                                                input logic bit_sel);
    return bit_sel ? node[NODE_W-1:PTR_W] : node[PTR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/binary_trie_min_xor_set.sv
// Top level of the binary trie minimum-xor set: node memory, walk sequencer.
// Depends on btmx_pkg and assert_macros.svh.
//
// Usage: after reset the block writes the chain for key 0 into the node
// memory, with busy high. A transaction is taken when start is high and busy
// is low. Xor-all (and the unused request code) finishes at once: done pulses
// in the next cycle and busy stays low. Insert and query walk the trie one key
// bit per cycle through the node memory, which has one read and one write
// port (one memory read per existing level, one write per new node and one to
// hook the first new node on), and done pulses in the first cycle that busy is
// low again. The result stands on min_value and status for the single cycle
// that done is high; the receiver cannot stall it, so it must take it then.
`default_nettype none
`include "assert_macros.svh"
module binary_trie_min_xor_set (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  output logic                      busy,
  input  wire  [1:0]                req_type,
  input  wire  [btmx_pkg::VAL_W-1:0] value,
  output logic                      done,
  output logic [btmx_pkg::VAL_W-1:0] min_value,
  output logic                      status
);
  import btmx_pkg::*;

  // Node memory: each word holds child 1 above child 0; a link of 0 is no child.
  logic [NODE_W-1:0] node_mem [NODE_POOL];
  logic [NODE_W-1:0] rd_data;
  logic              re, we;
  logic [PTR_W-1:0]  raddr, waddr;
  logic [NODE_W-1:0] wdata;

  state_t            state, state_next;
  logic [LVL_W-1:0]  init_idx, init_idx_next;
  logic [KEY_BITS-1:0] key_sr, key_sr_next;
  logic [KEY_BITS-1:0] ans_sr, ans_sr_next;
  logic [LVL_W-1:0]  lvl, lvl_next;
  logic [PTR_W-1:0]  cur, cur_next;
  logic              dead, dead_next;
  logic [CNT_W-1:0]  nodes_used, nodes_used_next;
  logic [VAL_W-1:0]  xor_mask, xor_mask_next;
  logic              done_next;
  logic [VAL_W-1:0]  min_value_next;
  logic              status_next;

  logic              key_bit;
  logic [PTR_W-1:0]  c_same, c_other, link;
  logic [CNT_W:0]    need_total;
  logic              diff;

  always_ff @(posedge clk) begin
    if (we) begin
      node_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= node_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      init_idx   <= '0;
      nodes_used <= CNT_W'(KEY_BITS + 1);
      xor_mask   <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      init_idx   <= init_idx_next;
      nodes_used <= nodes_used_next;
      xor_mask   <= xor_mask_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    key_sr    <= key_sr_next;
    ans_sr    <= ans_sr_next;
    lvl       <= lvl_next;
    cur       <= cur_next;
    dead      <= dead_next;
    min_value <= min_value_next;
    status    <= status_next;
  end

  assign busy    = (state != ST_IDLE);
  assign key_bit = key_sr[KEY_BITS-1];
  assign c_same  = child_of(rd_data, key_bit);
  assign c_other = child_of(rd_data, ~key_bit);
  assign link    = nodes_used[PTR_W-1:0] + PTR_W'(1);
  // Nodes in use plus those the remaining key bits would need.
  assign need_total = {1'b0, nodes_used} + (CNT_W+1)'(lvl);

  always_comb begin
    state_next      = state;
    init_idx_next   = init_idx;
    key_sr_next     = key_sr;
    ans_sr_next     = ans_sr;
    lvl_next        = lvl;
    cur_next        = cur;
    dead_next       = dead;
    nodes_used_next = nodes_used;
    xor_mask_next   = xor_mask;
    done_next       = 1'b0;
    min_value_next  = min_value;
    status_next     = status;
    re              = 1'b0;
    raddr           = '0;
    we              = 1'b0;
    waddr           = '0;
    wdata           = '0;
    diff            = 1'b0;

    unique case (state)
      ST_INIT: begin
        we    = 1'b1;
        waddr = PTR_W'(init_idx);
        if (init_idx < LVL_W'(KEY_BITS)) begin
          wdata = {{PTR_W{1'b0}}, PTR_W'(init_idx) + PTR_W'(1)};
        end
        if (init_idx == LVL_W'(KEY_BITS)) begin
          state_next = ST_IDLE;
        end else begin
          init_idx_next = init_idx + LVL_W'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_INSERT: begin
              key_sr_next = value ^ xor_mask;
              lvl_next    = LVL_W'(KEY_BITS);
              cur_next    = '0;
              re          = 1'b1;
              state_next  = ST_IWALK;
            end
            REQ_XOR: begin
              xor_mask_next  = xor_mask ^ value;
              done_next      = 1'b1;
              min_value_next = '0;
              status_next    = STATUS_DONE;
            end
            REQ_QUERY: begin
              key_sr_next = xor_mask;
              ans_sr_next = '0;
              dead_next   = 1'b0;
              lvl_next    = LVL_W'(KEY_BITS);
              re          = 1'b1;
              state_next  = ST_QWALK;
            end
            default: begin
              done_next      = 1'b1;
              min_value_next = '0;
              status_next    = STATUS_DONE;
            end
          endcase
        end
      end

      ST_IWALK: begin
        if (c_same != '0) begin
          if (lvl == LVL_W'(1)) begin
            done_next      = 1'b1;
            min_value_next = '0;
            status_next    = STATUS_DONE;
            state_next     = ST_IDLE;
          end else begin
            cur_next    = c_same;
            re          = 1'b1;
            raddr       = c_same;
            key_sr_next = {key_sr[KEY_BITS-2:0], 1'b0};
            lvl_next    = lvl - LVL_W'(1);
          end
        end else if (need_total > (CNT_W+1)'(NODE_POOL)) begin
          done_next      = 1'b1;
          min_value_next = '0;
          status_next    = STATUS_FULL;
          state_next     = ST_IDLE;
        end else begin
          // Hook the first new node onto the last existing one; lvl then
          // counts the new nodes still to be written.
          we    = 1'b1;
          waddr = cur;
          wdata = key_bit ? {nodes_used[PTR_W-1:0], rd_data[PTR_W-1:0]}
                          : {rd_data[NODE_W-1:PTR_W], nodes_used[PTR_W-1:0]};
          key_sr_next = {key_sr[KEY_BITS-2:0], 1'b0};
          state_next  = ST_ALLOC;
        end
      end

      ST_ALLOC: begin
        we    = 1'b1;
        waddr = nodes_used[PTR_W-1:0];
        if (lvl != LVL_W'(1)) begin
          wdata = key_bit ? {link, {PTR_W{1'b0}}} : {{PTR_W{1'b0}}, link};
        end
        nodes_used_next = nodes_used + CNT_W'(1);
        key_sr_next     = {key_sr[KEY_BITS-2:0], 1'b0};
        lvl_next        = lvl - LVL_W'(1);
        if (lvl == LVL_W'(1)) begin
          done_next      = 1'b1;
          min_value_next = '0;
          status_next    = STATUS_DONE;
          state_next     = ST_IDLE;
        end
      end

      ST_QWALK: begin
        priority if (dead) begin
          diff = 1'b0;
        end else if (c_same != '0) begin
          diff  = 1'b0;
          re    = 1'b1;
          raddr = c_same;
        end else if (c_other != '0) begin
          diff  = 1'b1;
          re    = 1'b1;
          raddr = c_other;
        end else begin
          // No child at all: the remaining answer bits stay zero.
          dead_next = 1'b1;
        end
        ans_sr_next = {ans_sr[KEY_BITS-2:0], diff};
        key_sr_next = {key_sr[KEY_BITS-2:0], 1'b0};
        lvl_next    = lvl - LVL_W'(1);
        if (lvl == LVL_W'(1)) begin
          re             = 1'b0;
          done_next      = 1'b1;
          min_value_next = {ans_sr[KEY_BITS-2:0], diff};
          status_next    = STATUS_DONE;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPLY(a_no_result_in_init, clk, rst, state == ST_INIT, !done)
  `ASSERT_IMPLY(a_alloc_in_pool, clk, rst, state == ST_ALLOC,
                nodes_used < CNT_W'(NODE_POOL))
  `ASSERT_IMPLY(a_full_only_from_insert, clk, rst, done && status,
                $past(state) == ST_IWALK)
  `ASSERT_ALWAYS(a_pool_grows, clk, rst, nodes_used >= $past(nodes_used))

endmodule
`default_nettype wire
